FILE: rtl/core/ssd_pkg.sv
// Shared types and constants of the SMBIOS structure decoder.
package ssd_pkg;

	// Default number of formatted-area bytes held per structure.
	localparam int CAPTURE_BYTES_DEF = 16;

	// Leading formatted-area bytes that feed any record field.
	localparam int REC_BYTES = 16;

	// Depth of the queue between classifier and decoder.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int HANDLE_W    = 16;
	localparam int ADDR_W      = 32;
	localparam int SIZE_W      = 35;
	localparam int RANGE_W     = 42;
	localparam int SCALE_SHIFT = 10;
	localparam int MB_SHIFT    = 20;

	localparam logic [7:0]          MIN_LENGTH     = 8'd4;
	localparam logic [HANDLE_W-1:0] SIZE_UNKNOWN   = 16'hffff;
	localparam logic [ADDR_W-1:0]   SPAN_LIMIT     = 32'd512;

	// Structure type codes.
	localparam logic [7:0] SMB_TYPE_PROC        = 8'd4;
	localparam logic [7:0] SMB_TYPE_MEM_ARRAY   = 8'd16;
	localparam logic [7:0] SMB_TYPE_MEM_DEVICE  = 8'd17;
	localparam logic [7:0] SMB_TYPE_ARRAY_MAP   = 8'd19;
	localparam logic [7:0] SMB_TYPE_DEVICE_MAP  = 8'd20;

	// Array use code for system memory, and where it sits.
	localparam logic [7:0] ARRAY_USE_SYSTEM = 8'h03;
	localparam int         ARRAY_USE_OFS    = 5;

	typedef enum logic [2:0] {
		KIND_PROC       = 3'd0,
		KIND_MEM_ARRAY  = 3'd1,
		KIND_MEM_DEVICE = 3'd2,
		KIND_ARRAY_MAP  = 3'd3,
		KIND_DEVICE_MAP = 3'd4
	} record_kind_t;

	typedef enum logic {
		PH_FORMATTED = 1'b0,
		PH_STRINGS   = 1'b1
	} phase_t;

	// One classified structure waiting for field decode.
	typedef struct packed {
		record_kind_t                kind;
		logic [REC_BYTES-1:0][7:0]   data;
	} job_t;

	typedef struct packed {
		record_kind_t          kind;
		logic [HANDLE_W-1:0]   own_handle;
		logic [HANDLE_W-1:0]   linked_handle;
		logic [HANDLE_W-1:0]   map_array_handle;
		logic [7:0]            small_value;
		logic [SIZE_W-1:0]     size_bytes;
	} record_base_t;

	// Queue status seen by the decoder.
	typedef struct packed {
		logic empty;
		job_t head;
	} queue_stat_t;

endpackage

FILE: rtl/core/ssd_if.sv
// Channel interfaces for table bytes and decoded records.
interface ssd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] table_byte;
	logic       final_byte;

	modport source(output valid, output table_byte, output final_byte, input ready);
	modport sink(input valid, input table_byte, input final_byte, output ready);
endinterface

interface ssd_rec_if;
	logic        valid;
	logic        ready;
	logic [2:0]  record_kind;
	logic [15:0] own_handle;
	logic [15:0] linked_handle;
	logic [15:0] map_array_handle;
	logic [7:0]  small_value;
	logic [34:0] size_bytes;
	logic [41:0] range_start;
	logic [41:0] range_end;

	modport source(output valid, output record_kind, output own_handle,
		output linked_handle, output map_array_handle, output small_value,
		output size_bytes, output range_start, output range_end, input ready);
	modport sink(input valid, input record_kind, input own_handle,
		input linked_handle, input map_array_handle, input small_value,
		input size_bytes, input range_start, input range_end, output ready);
endinterface

FILE: rtl/core/ssd_front.sv
// Byte walker: tracks structure boundaries and classifies finished formatted areas.
module ssd_front #(
	parameter int CAPTURE_BYTES = ssd_pkg::CAPTURE_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	ssd_byte_if.sink        tbl,
	input  logic            q_full,
	output logic            push,
	output ssd_pkg::job_t   push_job
);

	localparam int CAP_IDX_W = $clog2(CAPTURE_BYTES);

	ssd_pkg::phase_t phase_q, phase_d;
	logic [7:0] off_q, off_d;
	logic [7:0] len_q;
	logic       pz_q, pz_d;
	logic [7:0] store_q [CAPTURE_BYTES];

	logic       accept;
	logic [7:0] eff_len;
	logic       complete;
	logic       kind_ok;
	logic [7:0] cur_byte;

	assign tbl.ready = !q_full;
	assign accept    = tbl.valid && tbl.ready;
	assign cur_byte  = tbl.table_byte;
	assign eff_len   = (len_q < ssd_pkg::MIN_LENGTH) ? ssd_pkg::MIN_LENGTH : len_q;
	assign complete  = (phase_q == ssd_pkg::PH_FORMATTED)
		&& (({1'b0, off_q} + 9'd1) >= {1'b0, eff_len});

	// Next state.
	always_comb begin
		phase_d = phase_q;
		off_d   = off_q;
		pz_d    = pz_q;
		case (phase_q)
			ssd_pkg::PH_STRINGS: begin
				if (cur_byte == 8'd0 && pz_q) begin
					phase_d = ssd_pkg::PH_FORMATTED;
					off_d   = 8'd0;
					pz_d    = 1'b0;
				end else begin
					pz_d = (cur_byte == 8'd0);
				end
			end
			default: begin
				if (complete) begin
					phase_d = ssd_pkg::PH_STRINGS;
					off_d   = 8'd0;
					pz_d    = 1'b0;
				end else begin
					off_d = off_q + 8'd1;
				end
			end
		endcase
		if (tbl.final_byte) begin
			phase_d = ssd_pkg::PH_FORMATTED;
			off_d   = 8'd0;
			pz_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ssd_pkg::PH_FORMATTED;
			off_q   <= 8'd0;
			pz_q    <= 1'b0;
			len_q   <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			off_q   <= off_d;
			pz_q    <= pz_d;
			if (phase_q == ssd_pkg::PH_FORMATTED && off_q == 8'd1) begin
				len_q <= cur_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && phase_q == ssd_pkg::PH_FORMATTED
			&& off_q < 8'(CAPTURE_BYTES)) begin
			store_q[off_q[CAP_IDX_W-1:0]] <= cur_byte;
		end
	end

	// Outputs. At completion the offset is the last formatted byte, so every
	// byte at or below it belongs to this structure and the rest read as zero.
	always_comb begin
		push_job = '0;
		kind_ok  = 1'b0;
		for (int i = 0; i < ssd_pkg::REC_BYTES; i++) begin
			if (8'(i) == off_q) begin
				push_job.data[i] = cur_byte;
			end else if (8'(i) < off_q) begin
				push_job.data[i] = store_q[i];
			end else begin
				push_job.data[i] = 8'd0;
			end
		end
		case (push_job.data[0])
			ssd_pkg::SMB_TYPE_PROC: begin
				push_job.kind = ssd_pkg::KIND_PROC;
				kind_ok       = 1'b1;
			end
			ssd_pkg::SMB_TYPE_MEM_ARRAY: begin
				push_job.kind = ssd_pkg::KIND_MEM_ARRAY;
				kind_ok       = (push_job.data[ssd_pkg::ARRAY_USE_OFS]
					== ssd_pkg::ARRAY_USE_SYSTEM);
			end
			ssd_pkg::SMB_TYPE_MEM_DEVICE: begin
				push_job.kind = ssd_pkg::KIND_MEM_DEVICE;
				kind_ok       = 1'b1;
			end
			ssd_pkg::SMB_TYPE_ARRAY_MAP: begin
				push_job.kind = ssd_pkg::KIND_ARRAY_MAP;
				kind_ok       = 1'b1;
			end
			ssd_pkg::SMB_TYPE_DEVICE_MAP: begin
				push_job.kind = ssd_pkg::KIND_DEVICE_MAP;
				kind_ok       = 1'b1;
			end
			default: begin
				push_job.kind = ssd_pkg::KIND_PROC;
				kind_ok       = 1'b0;
			end
		endcase
		push = accept && complete && kind_ok;
	end

endmodule

FILE: rtl/core/ssd_queue.sv
// Short FIFO of classified structures between classifier and decoder.
module ssd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ssd_pkg::job_t        push_job,
	input  logic                 pop,
	output logic                 full,
	output ssd_pkg::queue_stat_t stat
);

	ssd_pkg::job_t                 mem_q [ssd_pkg::QUEUE_DEPTH];
	logic [ssd_pkg::QPTR_W-1:0]    wr_q, rd_q;
	logic [ssd_pkg::QCNT_W-1:0]    cnt_q;

	assign full       = (cnt_q == ssd_pkg::QCNT_W'(ssd_pkg::QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign stat.head  = mem_q[rd_q];

	function automatic logic [ssd_pkg::QPTR_W-1:0] bump(input logic [ssd_pkg::QPTR_W-1:0] p);
		if (p == ssd_pkg::QPTR_W'(ssd_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

endmodule

FILE: rtl/core/ssd_back.sv
// Field decoder: turns classified structures into records over two stages.
module ssd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ssd_pkg::queue_stat_t stat,
	output logic                 pop,
	ssd_rec_if.source            rec
);

	ssd_pkg::record_base_t       dec, base_s1, base_q;
	logic [ssd_pkg::ADDR_W-1:0]  dec_start, dec_end, start_s1, end_s1;
	logic                        dec_scale, scale_s1;
	logic [ssd_pkg::RANGE_W-1:0] start_q, end_q;
	logic                        s1_valid, out_valid_q, s1_adv;
	logic [ssd_pkg::HANDLE_W-1:0] u;
	logic [ssd_pkg::REC_BYTES-1:0][7:0] d;

	assign s1_adv = s1_valid && (!out_valid_q || rec.ready);
	assign pop    = !stat.empty && (!s1_valid || s1_adv);
	assign d      = stat.head.data;
	assign u      = {d[13], d[12]};

	always_comb begin
		dec            = '0;
		dec.kind       = stat.head.kind;
		dec.own_handle = {d[3], d[2]};
		dec_start      = '0;
		dec_end        = '0;
		dec_scale      = 1'b0;
		case (stat.head.kind)
			ssd_pkg::KIND_PROC: begin
				dec.small_value = d[8];
			end
			ssd_pkg::KIND_MEM_ARRAY: begin
				dec.small_value = d[13];
			end
			ssd_pkg::KIND_MEM_DEVICE: begin
				dec.linked_handle = {d[5], d[4]};
				if (u == ssd_pkg::SIZE_UNKNOWN) begin
					dec.size_bytes = '0;
				end else if (u[15]) begin
					dec.size_bytes = ssd_pkg::SIZE_W'({u[14:0], 10'd0});
				end else begin
					dec.size_bytes = {u[14:0], 20'd0};
				end
			end
			ssd_pkg::KIND_ARRAY_MAP, ssd_pkg::KIND_DEVICE_MAP: begin
				dec.linked_handle = u;
				if (stat.head.kind == ssd_pkg::KIND_DEVICE_MAP) begin
					dec.map_array_handle = {d[15], d[14]};
				end
				dec_start = {d[7], d[6], d[5], d[4]};
				dec_end   = {d[11], d[10], d[9], d[8]};
				dec_scale = (dec_end >= dec_start)
					&& ((dec_end - dec_start) < ssd_pkg::SPAN_LIMIT);
			end
			default: begin
				dec = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				s1_valid <= 1'b1;
			end else if (s1_adv) begin
				s1_valid <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (rec.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			base_s1  <= dec;
			start_s1 <= dec_start;
			end_s1   <= dec_end;
			scale_s1 <= dec_scale;
		end
		if (s1_adv) begin
			base_q <= base_s1;
			if (scale_s1) begin
				start_q <= {start_s1, 10'd0};
				end_q   <= {end_s1, 10'd0};
			end else begin
				start_q <= ssd_pkg::RANGE_W'(start_s1);
				end_q   <= ssd_pkg::RANGE_W'(end_s1);
			end
		end
	end

	assign rec.valid            = out_valid_q;
	assign rec.record_kind      = base_q.kind;
	assign rec.own_handle       = base_q.own_handle;
	assign rec.linked_handle    = base_q.linked_handle;
	assign rec.map_array_handle = base_q.map_array_handle;
	assign rec.small_value      = base_q.small_value;
	assign rec.size_bytes       = base_q.size_bytes;
	assign rec.range_start      = start_q;
	assign rec.range_end        = end_q;

endmodule

FILE: rtl/core/smbios_structure_decoder.sv
// Top level of the SMBIOS structure table decoder.
// Throughput: one table byte per cycle while the queue has room; a record at
// most once per four bytes. A record passes the queue write, the decode stage
// and the output register after the last byte of its formatted area is accepted.
// Reset: arst_n clears the byte walker, the queue pointers and all valid flags
// at once; no clearing pass, so the block takes bytes as soon as reset is released.
module smbios_structure_decoder #(
	parameter int CAPTURE_BYTES = ssd_pkg::CAPTURE_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ssd_byte_if.sink  tbl,
	ssd_rec_if.source rec
);

	// The front walks structure boundaries: header, formatted area of the
	// declared length (at least four bytes) and the string set that closes on
	// two zero bytes. When a formatted area finishes with a record type (a memory
	// array only for system memory use), the captured bytes and the record kind go
	// into a short queue as one item. A byte that marks the end of the table sends
	// the walker back to the header phase, so a truncated structure is simply dropped.

	logic                 q_push;
	logic                 q_pop;
	logic                 q_full;
	ssd_pkg::job_t        q_job;
	ssd_pkg::queue_stat_t q_stat;

	ssd_front #(
		.CAPTURE_BYTES(CAPTURE_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.tbl      (tbl),
		.q_full   (q_full),
		.push     (q_push),
		.push_job (q_job)
	);

	// The queue lets the walker keep taking bytes while a record waits at
	// the output.
	ssd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.pop      (q_pop),
		.full     (q_full),
		.stat     (q_stat)
	);

	// The back decodes handles, sizes and address ranges: the span test runs
	// in the first stage, the scaling by 1024 in the output register.
	ssd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (q_stat),
		.pop    (q_pop),
		.rec    (rec)
	);

	// The walker never writes into a full queue.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("structure pushed into full queue");

	// The decoder never takes from an empty queue.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("structure popped from empty queue");

	// Only map records carry an address range.
	a_range_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(rec.valid && rec.record_kind != ssd_pkg::KIND_ARRAY_MAP
			&& rec.record_kind != ssd_pkg::KIND_DEVICE_MAP)
		|-> (rec.range_start == '0 && rec.range_end == '0))
		else $error("range on a record without a mapping");

	// Only memory device records carry a size.
	a_size_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(rec.valid && rec.record_kind != ssd_pkg::KIND_MEM_DEVICE)
		|-> (rec.size_bytes == '0))
		else $error("size on a record that is not a memory device");

endmodule
